@@ hw/rtl/pulse_width_serial_decoder_assert.svh @@
// ----------------------------------------------------------------------------
// pulse_width_serial_decoder_assert.svh
// Assertion macros for the decoder's assembler module (pwsd_back). They sample on i_clk and
// are off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PULSE_WIDTH_SERIAL_DECODER_ASSERT_SVH
`define PULSE_WIDTH_SERIAL_DECODER_ASSERT_SVH

// Property that holds at every edge.
`define PWSD_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Property that must hold in the cycle after its trigger.
`define PWSD_ASSERT_NEXT(label, trig, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (expr)) else $error(msg);

`endif

@@ hw/rtl/pwsd_pkg.sv @@
// ----------------------------------------------------------------------------
// pwsd_pkg
// Types, widths and pulse windows of the pulse-width serial decoder.
// ----------------------------------------------------------------------------
package pwsd_pkg;

    localparam int TimeW    = 64;
    localparam int DiffW    = 23;
    localparam int LenW     = 3;
    localparam int BitIdxW  = 6;
    localparam int BytesMax = 5;
    localparam int PayloadW = 8 * BytesMax;
    localparam int QDepth   = 2;
    localparam int QPtrW    = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int QCntW    = $clog2(QDepth + 1);

    // Pulse windows in ns, inclusive
    localparam logic [DiffW-1:0] Bit0Lo  = DiffW'(300000);
    localparam logic [DiffW-1:0] Bit0Hi  = DiffW'(700000);
    localparam logic [DiffW-1:0] Bit1Lo  = DiffW'(800000);
    localparam logic [DiffW-1:0] Bit1Hi  = DiffW'(1200000);
    localparam logic [DiffW-1:0] Sync1Lo = DiffW'(1700000);
    localparam logic [DiffW-1:0] Sync1Hi = DiffW'(2300000);
    localparam logic [DiffW-1:0] Sync2Lo = DiffW'(2700000);
    localparam logic [DiffW-1:0] Sync2Hi = DiffW'(3300000);
    localparam logic [DiffW-1:0] Sync3Lo = DiffW'(3700000);
    localparam logic [DiffW-1:0] Sync3Hi = DiffW'(4300000);
    localparam logic [DiffW-1:0] Sync4Lo = DiffW'(4700000);
    localparam logic [DiffW-1:0] Sync4Hi = DiffW'(5300000);
    localparam logic [DiffW-1:0] Sync5Lo = DiffW'(5700000);
    localparam logic [DiffW-1:0] Sync5Hi = DiffW'(6300000);

    typedef enum logic [2:0] {
        CLS_BIT0  = 3'd0,
        CLS_BIT1  = 3'd1,
        CLS_SYNC1 = 3'd2,
        CLS_SYNC2 = 3'd3,
        CLS_SYNC3 = 3'd4,
        CLS_SYNC4 = 3'd5,
        CLS_SYNC5 = 3'd6,
        CLS_BAD   = 3'd7
    } t_pulse_class;

    function automatic logic [LenW-1:0] sync_len(input t_pulse_class cls);
        logic [LenW-1:0] len;
        case (cls)
            CLS_SYNC1: len = LenW'(1);
            CLS_SYNC2: len = LenW'(2);
            CLS_SYNC3: len = LenW'(3);
            CLS_SYNC4: len = LenW'(4);
            CLS_SYNC5: len = LenW'(5);
            default:   len = '0;
        endcase
        return len;
    endfunction

endpackage

@@ hw/rtl/pwsd_queue.sv @@
// ----------------------------------------------------------------------------
// pwsd_queue
// Small FIFO of pulse classes between the classifier and the assembler.
// ----------------------------------------------------------------------------
module pwsd_queue import pwsd_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push_valid,
    output logic         o_push_ready,
    input  t_pulse_class i_push_cls,
    output logic         o_pop_valid,
    input  logic         i_pop_ready,
    output t_pulse_class o_pop_cls
);

    t_pulse_class     r_mem [QDepth];
    logic [QPtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCntW-1:0] r_count,  n_count;
    logic             push, pop;

    assign o_push_ready = (r_count != QCntW'(QDepth));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cls    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPtrW'(QDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPtrW'(QDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cls;
        end
    end

endmodule

@@ hw/rtl/pwsd_front.sv @@
// ----------------------------------------------------------------------------
// pwsd_front
// Edge intake: keeps the pulse start time, measures each pulse and sorts
// its length into a bit, a sync or an invalid class.
// ----------------------------------------------------------------------------
module pwsd_front import pwsd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_line_level,
    input  logic [TimeW-1:0] i_edge_time_ns,
    output logic             o_cls_valid,
    input  logic             i_cls_ready,
    output t_pulse_class     o_cls
);

    logic [TimeW-1:0] r_start;
    logic [DiffW-1:0] r_diff;
    logic             r_diff_short;
    logic             r_diff_valid, n_diff_valid;
    logic [TimeW-1:0] diff;
    logic             accept, push;

    assign push       = r_diff_valid && i_cls_ready;
    assign o_in_ready = !r_diff_valid || i_cls_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign diff       = i_edge_time_ns - r_start;

    always_comb begin
        n_diff_valid = r_diff_valid;
        if (push) begin
            n_diff_valid = 1'b0;
        end
        if (accept && !i_line_level) begin
            n_diff_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start      <= '0;
            r_diff_valid <= 1'b0;
        end else begin
            r_diff_valid <= n_diff_valid;
            if (accept && i_line_level) begin
                r_start <= i_edge_time_ns;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !i_line_level) begin
            r_diff       <= diff[DiffW-1:0];
            r_diff_short <= (diff[TimeW-1:DiffW] == '0);
        end
    end

    always_comb begin
        o_cls = CLS_BAD;
        if (r_diff_short) begin
            if (r_diff >= Bit0Lo && r_diff <= Bit0Hi) begin
                o_cls = CLS_BIT0;
            end else if (r_diff >= Bit1Lo && r_diff <= Bit1Hi) begin
                o_cls = CLS_BIT1;
            end else if (r_diff >= Sync1Lo && r_diff <= Sync1Hi) begin
                o_cls = CLS_SYNC1;
            end else if (r_diff >= Sync2Lo && r_diff <= Sync2Hi) begin
                o_cls = CLS_SYNC2;
            end else if (r_diff >= Sync3Lo && r_diff <= Sync3Hi) begin
                o_cls = CLS_SYNC3;
            end else if (r_diff >= Sync4Lo && r_diff <= Sync4Hi) begin
                o_cls = CLS_SYNC4;
            end else if (r_diff >= Sync5Lo && r_diff <= Sync5Hi) begin
                o_cls = CLS_SYNC5;
            end
        end
    end

    assign o_cls_valid = r_diff_valid;

endmodule

@@ hw/rtl/pwsd_back.sv @@
// ----------------------------------------------------------------------------
// pwsd_back
// Message assembler: opens a message on sync, shifts data bits MSB-first
// into the bytes and holds the finished message in the output register.
// ----------------------------------------------------------------------------
`include "pulse_width_serial_decoder_assert.svh"

module pwsd_back import pwsd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cls_valid,
    output logic                o_cls_ready,
    input  t_pulse_class        i_cls,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [LenW-1:0]     o_message_length,
    output logic [PayloadW-1:0] o_message_payload
);

    logic                r_receiving, n_receiving;
    logic [LenW-1:0]     r_expected,  n_expected;
    logic [BitIdxW-1:0]  r_bit_index, n_bit_index;
    logic [PayloadW-1:0] r_payload,   n_payload;
    logic                r_out_valid, n_out_valid;
    logic [LenW-1:0]     r_out_len;
    logic [PayloadW-1:0] r_out_payload;
    logic                pop, emit, bit_val;
    logic [2:0]          byte_idx;

    assign o_cls_ready = !r_out_valid || i_out_ready;
    assign pop         = i_cls_valid && o_cls_ready;
    assign byte_idx    = r_bit_index[BitIdxW-1:3];
    assign bit_val     = (i_cls == CLS_BIT1);

    always_comb begin
        n_receiving = r_receiving;
        n_expected  = r_expected;
        n_bit_index = r_bit_index;
        n_payload   = r_payload;
        emit        = 1'b0;
        if (pop) begin
            case (i_cls)
                CLS_BIT0, CLS_BIT1: begin
                    if (r_receiving) begin
                        for (int i = 0; i < BytesMax; i++) begin
                            if (byte_idx == 3'(i)) begin
                                n_payload[PayloadW-1-8*i -: 8] =
                                    {r_payload[PayloadW-2-8*i -: 7], bit_val};
                            end
                        end
                        n_bit_index = r_bit_index + 1'b1;
                        if (n_bit_index == {r_expected, 3'b000}) begin
                            emit        = 1'b1;
                            n_receiving = 1'b0;
                        end
                    end
                end
                CLS_SYNC1, CLS_SYNC2, CLS_SYNC3, CLS_SYNC4, CLS_SYNC5: begin
                    n_receiving = 1'b1;
                    n_expected  = sync_len(i_cls);
                    n_bit_index = '0;
                    n_payload   = '0;
                end
                default: begin
                    n_receiving = 1'b0;
                    n_expected  = '0;
                    n_bit_index = '0;
                end
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving <= 1'b0;
            r_expected  <= '0;
            r_bit_index <= '0;
            r_payload   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_receiving <= n_receiving;
            r_expected  <= n_expected;
            r_bit_index <= n_bit_index;
            r_payload   <= n_payload;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_len     <= r_expected;
            r_out_payload <= n_payload;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_message_length  = r_out_len;
    assign o_message_payload = r_out_payload;

    `PWSD_ASSERT_ALWAYS(a_open_has_len, !r_receiving || (r_expected != '0),
        "open message without length")
    `PWSD_ASSERT_ALWAYS(a_idx_in_range,
        !r_receiving || (r_bit_index < {r_expected, 3'b000}),
        "bit index past announced length")
    `PWSD_ASSERT_NEXT(a_emit_closes, emit, !r_receiving && r_out_valid,
        "message not closed after emit")
    `PWSD_ASSERT_ALWAYS(a_out_len_ok,
        !r_out_valid || (r_out_len != '0 && r_out_len <= LenW'(BytesMax)),
        "output length out of range")

endmodule

@@ hw/rtl/pulse_width_serial_decoder.sv @@
// ----------------------------------------------------------------------------
// pulse_width_serial_decoder
// Decodes an active-high single-wire pulse-width line into 1..5 byte messages.
// ----------------------------------------------------------------------------
// Takes one edge transfer per cycle, back to back, unless a measured pulse
// waits for room in the class FIFO. An edge with level 1 only records the
// pulse start time; an edge with level 0 measures the pulse and yields at
// most one message, which reaches the output through the pulse measurement
// register, then the class FIFO, then the output register. The two-entry
// class FIFO lets the edge side keep taking transfers while a finished
// message waits for the sink, until the FIFO fills.
// ----------------------------------------------------------------------------
module pulse_width_serial_decoder import pwsd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_line_level,
    input  logic [TimeW-1:0]    i_edge_time_ns,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [LenW-1:0]     o_message_length,
    output logic [PayloadW-1:0] o_message_payload
);

    logic         front_valid, front_ready;
    t_pulse_class front_cls;
    logic         back_valid, back_ready;
    t_pulse_class back_cls;

    pwsd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_line_level   (i_line_level),
        .i_edge_time_ns (i_edge_time_ns),
        .o_cls_valid    (front_valid),
        .i_cls_ready    (front_ready),
        .o_cls          (front_cls)
    );

    pwsd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_cls   (front_cls),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_cls    (back_cls)
    );

    pwsd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cls_valid       (back_valid),
        .o_cls_ready       (back_ready),
        .i_cls             (back_cls),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_message_length  (o_message_length),
        .o_message_payload (o_message_payload)
    );

endmodule
